// ===== src/vpsc_pkg.sv =====
// Shared types and constants for the velocity PID share controller.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package vpsc_pkg;

  // Field widths
  localparam int GAIN_W  = 32;
  localparam int TGT_W   = 47;
  localparam int SHARE_W = 16;
  localparam int ERR_W   = 48;
  localparam int DIFF_W  = 49;  // first difference of the error
  localparam int DD_W    = 50;  // second difference of the error

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_FLR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_CEIL = 3'd6;

  // Reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 32'd65536;
  localparam logic [SHARE_W-1:0] SHARES_RST     = 16'd100;
  localparam logic [SHARE_W-1:0] SHARE_FLR_RST  = 16'd1;
  localparam logic [SHARE_W-1:0] SHARE_CEIL_RST = 16'd1000;

  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Digit-serial multiplier geometry
  localparam int DIGIT_W     = 8;
  localparam int MCAND_W     = 50;
  localparam int MPLR_W      = 88;
  localparam int PROD_W      = MCAND_W + MPLR_W;
  localparam int STEP_W      = 4;
  localparam int GAIN_STEPS  = GAIN_W / DIGIT_W;
  localparam int INNER_STEPS = MPLR_W / DIGIT_W;
  // A gain-sized multiplier leaves its product in the top bits of the result.
  localparam int SHORT_LSB   = MPLR_W - GAIN_W;

  // Bracketed sum of the increment, signed
  localparam int ACC_W = 83;

  // Increment saturation
  localparam int INC_W = 18;
  localparam logic [INC_W-1:0] INC_LIMIT = 18'd131072;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [TGT_W-1:0]   target;
    logic [SHARE_W-1:0] share_floor;
    logic [SHARE_W-1:0] share_ceil;
    logic               shares_load;
    logic [SHARE_W-1:0] start_shares;
  } vpsc_cfg_t;

endpackage

`default_nettype wire

// ===== src/vpsc_serial_mul.sv =====
// Digit-serial unsigned multiplier: one multiplier digit per cycle, LSB first.
// Depends on vpsc_pkg for the digit and step-count widths.
`default_nettype none

module vpsc_serial_mul
  import vpsc_pkg::*;
#(
  parameter int MC_W = MCAND_W,
  parameter int MP_W = MPLR_W,
  parameter int DG_W = DIGIT_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [STEP_W-1:0]    steps_i,
  input  logic [MC_W-1:0]      mcand_i,
  input  logic [MP_W-1:0]      mplr_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [MC_W+MP_W-1:0] prod_o
);

  localparam int SUM_W = MC_W + DG_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [MC_W-1:0]   mc_q;
  logic [MC_W-1:0]   ph_q;
  logic [MP_W-1:0]   pl_q;
  logic [SUM_W-1:0]  pp;
  logic [SUM_W-1:0]  sum;

  // High partial plus multiplicand times the current digit; the low digit
  // of the sum is final and shifts into the top of the low register.
  assign pp  = SUM_W'(mc_q) * SUM_W'(pl_q[DG_W-1:0]);
  assign sum = SUM_W'(ph_q) + pp;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q <= mcand_i;
      ph_q <= '0;
      pl_q <= mplr_i;
    end else if (busy_q) begin
      ph_q <= sum[SUM_W-1:DG_W];
      pl_q <= {sum[DG_W-1:0], pl_q[MP_W-1:DG_W]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = {ph_q, pl_q};

  a_last_step_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == STEP_W'(1)) |=> (done_q && !busy_q))
    else $error("multiplier did not finish after its last digit");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !$past(start_i)))
    else $error("multiplier done without a running product");

  a_busy_has_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("multiplier running with no digits left");

endmodule

`default_nettype wire

// ===== src/vpsc_cfg_regs.sv =====
// Configuration register file of the velocity PID share controller.
// Depends on vpsc_pkg for register indexes, reset values and the config struct.
`default_nettype none

module vpsc_cfg_regs
  import vpsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output vpsc_cfg_t             cfg_o
);

  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [TGT_W-1:0]   target_q;
  logic [SHARE_W-1:0] floor_q, ceil_q;
  logic               wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= '0;
      gain_d_q <= '0;
      target_q <= '0;
      floor_q  <= SHARE_FLR_RST;
      ceil_q   <= SHARE_CEIL_RST;
    end else if (wr) begin
      case (cfg_index_i)
        REG_GAIN_P:     gain_p_q <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:     gain_i_q <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:     gain_d_q <= cfg_data_i[GAIN_W-1:0];
        REG_TARGET:     target_q <= cfg_data_i[TGT_W-1:0];
        REG_SHARE_FLR:  floor_q  <= cfg_data_i[SHARE_W-1:0];
        REG_SHARE_CEIL: ceil_q   <= cfg_data_i[SHARE_W-1:0];
        default: ;
      endcase
    end
  end

  // The start value is not kept: a write loads the share state directly.
  always_comb begin
    cfg_o.gain_p       = gain_p_q;
    cfg_o.gain_i       = gain_i_q;
    cfg_o.gain_d       = gain_d_q;
    cfg_o.target       = target_q;
    cfg_o.share_floor  = floor_q;
    cfg_o.share_ceil   = ceil_q;
    cfg_o.shares_load  = wr && (cfg_index_i == REG_START);
    cfg_o.start_shares = cfg_data_i[SHARE_W-1:0];
  end

endmodule

`default_nettype wire

// ===== src/velocity_pid_share_controller.sv =====
// An accepted request runs to a registered result before a new request is taken;
// the finish state waits while a held result is stalled at the output.
// The work is done by the shared 8-bit digit-serial multiplier: 4 digits each for
// the integral and derivative gains, 11 digits for the proportional product.
// Reset (asynchronous, active low) clears the error history, loads 100 shares
// and restores the register defaults; the block then accepts at once.
`default_nettype none

module velocity_pid_share_controller
  import vpsc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [TGT_W-1:0]         backlog_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SHARE_W-1:0]       shares_o,
  output logic signed [ERR_W-1:0]  error_now_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_D2    = 4'd2;
  localparam logic [3:0] S_MUL_I = 4'd3;
  localparam logic [3:0] S_MUL_D = 4'd4;
  localparam logic [3:0] S_MAG   = 4'd5;
  localparam logic [3:0] S_MUL_P = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  localparam int SUM_W = INC_W + 2;
  localparam int Q_LSB = 2 * GAIN_FRAC_BITS;

  vpsc_cfg_t cfg;

  logic [3:0]         state_q, state_d;
  logic [ERR_W-1:0]   e_q, e_d, e1_q, e2_q;
  logic [DIFF_W-1:0]  d1_q, d1_d, dt_q, dt_d;
  logic [DD_W-1:0]    d2_q, d2_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               neg_q, neg_d;
  logic [INC_W:0]     inc_q, inc_d;
  logic [SHARE_W-1:0] share_q;
  logic               out_valid_q;
  logic [SHARE_W-1:0] out_shares_q;
  logic [ERR_W-1:0]   out_err_q;
  logic               fin_fire;

  logic               mul_start;
  logic [STEP_W-1:0]  mul_steps;
  logic [MCAND_W-1:0] mul_mcand;
  logic [MPLR_W-1:0]  mul_mplr;
  logic               mul_busy;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;

  logic [ERR_W-1:0]   e_mag;
  logic [DD_W-1:0]    d2_mag;
  logic [ACC_W-1:0]   acc_mag;
  logic [GAIN_W-1:0]  gi_mag, gd_mag, gp_mag;
  logic [ACC_W-1:0]   pe;
  logic [ACC_W-1:0]   acc_acc;
  logic               hi_nz;
  logic [INC_W-1:0]   q_lo, inc_mag;
  logic [SUM_W-1:0]   sum_raw, sum_hi, ceil_x, floor_x;
  logic [SHARE_W-1:0] share_new;

  vpsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vpsc_serial_mul #(
    .MC_W (MCAND_W),
    .MP_W (MPLR_W),
    .DG_W (DIGIT_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .steps_i (mul_steps),
    .mcand_i (mul_mcand),
    .mplr_i  (mul_mplr),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Magnitudes; the multiplier works on unsigned operands and neg_q keeps the sign.
  assign e_mag   = e_q[ERR_W-1] ? (~e_q + ERR_W'(1)) : e_q;
  assign d2_mag  = d2_q[DD_W-1] ? (~d2_q + DD_W'(1)) : d2_q;
  assign acc_mag = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
  assign gi_mag  = cfg.gain_i[GAIN_W-1] ? (~cfg.gain_i + GAIN_W'(1)) : cfg.gain_i;
  assign gd_mag  = cfg.gain_d[GAIN_W-1] ? (~cfg.gain_d + GAIN_W'(1)) : cfg.gain_d;
  assign gp_mag  = cfg.gain_p[GAIN_W-1] ? (~cfg.gain_p + GAIN_W'(1)) : cfg.gain_p;

  // Gain products sit in the top bits of the multiplier result.
  assign pe      = ACC_W'(mul_prod[PROD_W-1:SHORT_LSB]);
  assign acc_acc = neg_q ? (acc_q - pe) : (acc_q + pe);

  // Drop the 2F fraction bits and saturate the magnitude of the increment.
  assign hi_nz   = |(mul_prod >> (Q_LSB + INC_W));
  assign q_lo    = mul_prod[Q_LSB +: INC_W];
  assign inc_mag = (hi_nz || (q_lo > INC_LIMIT)) ? INC_LIMIT : q_lo;

  // Ceiling clamp first, then floor, on a signed sum that cannot overflow.
  assign sum_raw = {{(SUM_W-SHARE_W){1'b0}}, share_q} + {inc_q[INC_W], inc_q};
  assign ceil_x  = {{(SUM_W-SHARE_W){1'b0}}, cfg.share_ceil};
  assign floor_x = {{(SUM_W-SHARE_W){1'b0}}, cfg.share_floor};
  assign sum_hi  = ($signed(sum_raw) > $signed(ceil_x)) ? ceil_x : sum_raw;
  assign share_new = ($signed(sum_hi) < $signed(floor_x)) ? cfg.share_floor
                                                          : sum_hi[SHARE_W-1:0];

  always_comb begin
    state_d   = state_q;
    e_d       = e_q;
    d1_d      = d1_q;
    dt_d      = dt_q;
    d2_d      = d2_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    inc_d     = inc_q;
    fin_fire  = 1'b0;
    mul_start = 1'b0;
    mul_steps = STEP_W'(GAIN_STEPS);
    mul_mcand = '0;
    mul_mplr  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          e_d     = {1'b0, cfg.target} - {1'b0, backlog_sample_i};
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        d1_d    = {e_q[ERR_W-1], e_q} - {e1_q[ERR_W-1], e1_q};
        dt_d    = {e2_q[ERR_W-1], e2_q} - {e1_q[ERR_W-1], e1_q};
        state_d = S_D2;
      end
      S_D2: begin
        d2_d      = {d1_q[DIFF_W-1], d1_q} + {dt_q[DIFF_W-1], dt_q};
        acc_d     = {{(ACC_W-DIFF_W){d1_q[DIFF_W-1]}}, d1_q} << GAIN_FRAC_BITS;
        mul_start = 1'b1;
        mul_mcand = MCAND_W'(e_mag);
        mul_mplr  = MPLR_W'(gi_mag);
        neg_d     = e_q[ERR_W-1] ^ cfg.gain_i[GAIN_W-1];
        state_d   = S_MUL_I;
      end
      S_MUL_I: begin
        if (mul_done) begin
          acc_d     = acc_acc;
          mul_start = 1'b1;
          mul_mcand = MCAND_W'(d2_mag);
          mul_mplr  = MPLR_W'(gd_mag);
          neg_d     = d2_q[DD_W-1] ^ cfg.gain_d[GAIN_W-1];
          state_d   = S_MUL_D;
        end
      end
      S_MUL_D: begin
        if (mul_done) begin
          acc_d   = acc_acc;
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        mul_start = 1'b1;
        mul_steps = STEP_W'(INNER_STEPS);
        mul_mcand = MCAND_W'(gp_mag);
        mul_mplr  = MPLR_W'(acc_mag);
        neg_d     = acc_q[ACC_W-1] ^ cfg.gain_p[GAIN_W-1];
        state_d   = S_MUL_P;
      end
      S_MUL_P: begin
        if (mul_done) begin
          inc_d   = neg_q ? (~{1'b0, inc_mag} + (INC_W+1)'(1)) : {1'b0, inc_mag};
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          fin_fire = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      e1_q        <= '0;
      e2_q        <= '0;
      share_q     <= SHARES_RST;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin_fire) begin
        e2_q    <= e1_q;
        e1_q    <= e_q;
        share_q <= share_new;
      end else if (cfg.shares_load) begin
        share_q <= cfg.start_shares;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    d1_q  <= d1_d;
    dt_q  <= dt_d;
    d2_q  <= d2_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
    inc_q <= inc_d;
    if (fin_fire) begin
      out_shares_q <= share_new;
      out_err_q    <= e_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign shares_o    = out_shares_q;
  assign error_now_o = out_err_q;

  a_idle_mul_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !mul_busy)
    else $error("request taken while the multiplier is still running");

  a_done_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL_I || state_q == S_MUL_D || state_q == S_MUL_P))
    else $error("multiplier finished outside a multiply step");

  a_fin_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished item did not reach the output register");

endmodule

`default_nettype wire
